// ===== src/prnf_pkg.sv =====
// Shared types, constants and character helpers for the padded radix number formatter.
package prnf_pkg;

  // Field widths of the channel words
  localparam int VALUE_W = 64;
  localparam int MODE_W  = 2;
  localparam int FIELD_W = 7;
  localparam int CHAR_W  = 8;

  // Digit buffer holds the longest digit string (binary of a 64-bit value)
  localparam int DIG_MAX    = 64;
  localparam int DIGIT_BITS = 4 * DIG_MAX;

  // Counters for positions, digit counts and field widths (8 bits, up to 255)
  localparam int CNT_W = 8;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Radix codes
  localparam logic [MODE_W-1:0] MODE_BIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OCT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEC = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HEX = 2'd3;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

  // What a run of output positions holds
  typedef enum logic [1:0] {
    CK_MINUS,
    CK_SPACE,
    CK_ZERO,
    CK_DIGIT
  } char_kind_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DABBLE,
    FR_DIGITS,
    FR_PUSH
  } fr_state_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } bk_state_t;

  // One formatted number: digits most significant at the top, and three runs
  // of positions [0,b1), [b1,b2), [b2,total) with their kinds.
  typedef struct packed {
    logic [DIGIT_BITS-1:0] digits;
    logic                  upper;
    char_kind_t            kind0;
    char_kind_t            kind1;
    char_kind_t            kind2;
    logic [CNT_W-1:0]      b1;
    logic [CNT_W-1:0]      b2;
    logic [CNT_W-1:0]      total;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d <= 4'd9) begin
      digit_char = CHAR_ZERO + CHAR_W'(d);
    end else begin
      digit_char = base + CHAR_W'(d) - 8'd10;
    end
  endfunction

endpackage

// ===== src/prnf_in_if.sv =====
// Input channel carrying one number and its formatting choices per word.
interface prnf_in_if;
  logic                               valid;
  logic                               ready;
  logic [prnf_pkg::VALUE_W-1:0]       value;
  logic [prnf_pkg::MODE_W-1:0]        mode;
  logic [prnf_pkg::FIELD_W-1:0]       width;
  logic                               left_align;
  logic                               zero_pad;
  logic                               upper_case;
  logic                               negative;

  modport source (
    output valid, value, mode, width, left_align, zero_pad, upper_case, negative,
    input  ready
  );
  modport sink (
    input  valid, value, mode, width, left_align, zero_pad, upper_case, negative,
    output ready
  );
endinterface

// ===== src/prnf_out_if.sv =====
// Output channel carrying one ASCII character per word.
interface prnf_out_if;
  logic                          valid;
  logic                          ready;
  logic [prnf_pkg::CHAR_W-1:0]   char_code;
  logic                          last;

  modport source (
    output valid, char_code, last,
    input  ready
  );
  modport sink (
    input  valid, char_code, last,
    output ready
  );
endinterface

// ===== src/prnf_front.sv =====
// Front end: accepts a number, converts it to a digit string and describes the field layout.
module prnf_front #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_WIDTH  = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  prnf_in_if.sink              number,
  output prnf_pkg::job_t       job,
  output logic                 job_valid,
  input  logic                 job_ready
);

  localparam int BCD_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int WORK_W     = (VALUE_BITS > BCD_W) ? VALUE_BITS : BCD_W;
  localparam int ITER_W     = $clog2(VALUE_BITS + 1);

  prnf_pkg::fr_state_t state, state_next;

  logic [prnf_pkg::MODE_W-1:0]     mode;
  logic [prnf_pkg::CNT_W-1:0]      want;
  logic                            left;
  logic                            zeros;
  logic                            upper;
  logic                            neg;
  logic [WORK_W-1:0]               work;
  logic [BCD_W-1:0]                bcd;
  logic [ITER_W-1:0]               iter;
  logic [prnf_pkg::CNT_W-1:0]      nd;
  logic [prnf_pkg::DIGIT_BITS-1:0] digbuf;

  logic [BCD_W-1:0]                bcd_adj;
  logic [BCD_W-1:0]                bcd_shift;
  logic                            last_iter;
  logic [WORK_W-1:0]               work_shift;
  logic [3:0]                      digit;
  logic                            digits_done;
  logic [prnf_pkg::CNT_W-1:0]      len;
  logic [prnf_pkg::CNT_W-1:0]      fw;
  logic [prnf_pkg::CNT_W-1:0]      pad;
  logic [prnf_pkg::CNT_W-1:0]      neg_cnt;

  // Double dabble: add three to every BCD digit of five or more, then shift
  always_comb begin
    for (int j = 0; j < BCD_DIGITS; j++) begin
      bcd_adj[4*j +: 4] = (bcd[4*j +: 4] >= 4'd5) ? bcd[4*j +: 4] + 4'd3 : bcd[4*j +: 4];
    end
  end
  assign bcd_shift = {bcd_adj[BCD_W-2:0], work[VALUE_BITS-1]};
  assign last_iter = (iter == ITER_W'(VALUE_BITS - 1));

  // Peel the least significant digit off the work word
  always_comb begin
    case (mode)
      prnf_pkg::MODE_BIN: begin
        digit      = {3'b000, work[0]};
        work_shift = work >> 1;
      end
      prnf_pkg::MODE_OCT: begin
        digit      = {1'b0, work[2:0]};
        work_shift = work >> 3;
      end
      default: begin
        digit      = work[3:0];
        work_shift = work >> 4;
      end
    endcase
  end
  assign digits_done = (work_shift == '0);

  // Field layout
  assign neg_cnt = prnf_pkg::CNT_W'(neg);
  assign len     = nd + neg_cnt;
  assign fw      = (want > len) ? want : len;
  assign pad     = fw - len;

  always_comb begin
    job.digits = digbuf;
    job.upper  = upper;
    job.total  = (fw > prnf_pkg::CNT_W'(MAX_WIDTH)) ? prnf_pkg::CNT_W'(MAX_WIDTH) : fw;
    if (left) begin
      job.kind0 = prnf_pkg::CK_MINUS;
      job.kind1 = prnf_pkg::CK_DIGIT;
      job.kind2 = prnf_pkg::CK_SPACE;
      job.b1    = neg_cnt;
      job.b2    = len;
    end else if (zeros) begin
      job.kind0 = prnf_pkg::CK_MINUS;
      job.kind1 = prnf_pkg::CK_ZERO;
      job.kind2 = prnf_pkg::CK_DIGIT;
      job.b1    = neg_cnt;
      job.b2    = neg_cnt + pad;
    end else begin
      job.kind0 = prnf_pkg::CK_SPACE;
      job.kind1 = prnf_pkg::CK_MINUS;
      job.kind2 = prnf_pkg::CK_DIGIT;
      job.b1    = pad;
      job.b2    = neg_cnt + pad;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      prnf_pkg::FR_IDLE: begin
        if (number.valid) begin
          state_next = (number.mode == prnf_pkg::MODE_DEC) ? prnf_pkg::FR_DABBLE
                                                          : prnf_pkg::FR_DIGITS;
        end
      end
      prnf_pkg::FR_DABBLE: begin
        if (last_iter) state_next = prnf_pkg::FR_DIGITS;
      end
      prnf_pkg::FR_DIGITS: begin
        if (digits_done) state_next = prnf_pkg::FR_PUSH;
      end
      prnf_pkg::FR_PUSH: begin
        if (job_ready) state_next = prnf_pkg::FR_IDLE;
      end
      default: state_next = prnf_pkg::FR_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    number.ready = (state == prnf_pkg::FR_IDLE);
    job_valid    = (state == prnf_pkg::FR_PUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prnf_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      prnf_pkg::FR_IDLE: begin
        if (number.valid) begin
          mode  <= number.mode;
          want  <= prnf_pkg::CNT_W'(number.width);
          left  <= number.left_align;
          zeros <= number.zero_pad;
          upper <= number.upper_case;
          neg   <= number.negative && (number.mode != prnf_pkg::MODE_BIN);
          work  <= WORK_W'(number.value[VALUE_BITS-1:0]);
          bcd   <= '0;
          iter  <= '0;
          nd    <= '0;
        end
      end
      prnf_pkg::FR_DABBLE: begin
        bcd  <= bcd_shift;
        iter <= iter + 1'b1;
        if (last_iter) begin
          work <= WORK_W'(bcd_shift);
        end else begin
          work <= {work[WORK_W-2:0], 1'b0};
        end
      end
      prnf_pkg::FR_DIGITS: begin
        work   <= work_shift;
        digbuf <= {digit, digbuf[prnf_pkg::DIGIT_BITS-1:4]};
        nd     <= nd + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/prnf_queue.sv =====
// Short job queue between the front and back ends.
module prnf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  prnf_pkg::job_t       in_job,
  input  logic                 in_valid,
  output logic                 in_ready,
  output prnf_pkg::job_t       out_job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output prnf_pkg::q_status_t  status
);

  prnf_pkg::job_t                entries [prnf_pkg::QUEUE_DEPTH];
  logic [prnf_pkg::QPTR_W-1:0]   wr_ptr;
  logic [prnf_pkg::QPTR_W-1:0]   rd_ptr;
  logic [prnf_pkg::QCNT_W-1:0]   count;
  logic                          push;
  logic                          pop;

  assign status.full  = (count == prnf_pkg::QCNT_W'(prnf_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign in_ready     = !status.full;
  assign out_valid    = !status.empty;
  assign out_job      = entries[rd_ptr];
  assign push         = in_valid && in_ready;
  assign pop          = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == prnf_pkg::QPTR_W'(prnf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == prnf_pkg::QPTR_W'(prnf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_job;
    end
  end

endmodule

// ===== src/prnf_back.sv =====
// Back end: walks the field of one job and sends one character per word.
module prnf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  prnf_pkg::job_t       job,
  input  logic                 job_valid,
  output logic                 job_ready,
  prnf_out_if.source           chars
);

  prnf_pkg::bk_state_t state, state_next;

  prnf_pkg::job_t                cur;
  logic [prnf_pkg::CNT_W-1:0]    pos;
  logic                          o_valid;
  logic [prnf_pkg::CHAR_W-1:0]   o_char;
  logic                          o_last;

  logic                          step;
  logic                          is_last;
  prnf_pkg::char_kind_t          kind;
  logic [prnf_pkg::CHAR_W-1:0]   ch;

  assign is_last = (pos + 1'b1 == cur.total);

  always_comb begin
    if (pos < cur.b1) begin
      kind = cur.kind0;
    end else if (pos < cur.b2) begin
      kind = cur.kind1;
    end else begin
      kind = cur.kind2;
    end
  end

  always_comb begin
    case (kind)
      prnf_pkg::CK_MINUS: ch = prnf_pkg::CHAR_MINUS;
      prnf_pkg::CK_ZERO:  ch = prnf_pkg::CHAR_ZERO;
      prnf_pkg::CK_DIGIT: ch = prnf_pkg::digit_char(
                                 cur.digits[prnf_pkg::DIGIT_BITS-1 -: 4], cur.upper);
      default:            ch = prnf_pkg::CHAR_SPACE;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      prnf_pkg::BK_IDLE: begin
        if (job_valid) state_next = prnf_pkg::BK_EMIT;
      end
      prnf_pkg::BK_EMIT: begin
        if (step && is_last) state_next = prnf_pkg::BK_IDLE;
      end
      default: state_next = prnf_pkg::BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    job_ready = (state == prnf_pkg::BK_IDLE);
    step      = (state == prnf_pkg::BK_EMIT) && (!o_valid || chars.ready);
  end

  assign chars.valid     = o_valid;
  assign chars.char_code = o_char;
  assign chars.last      = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= prnf_pkg::BK_IDLE;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (step) begin
        o_valid <= 1'b1;
      end else if (chars.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == prnf_pkg::BK_IDLE && job_valid) begin
      cur <= job;
      pos <= '0;
    end else if (step) begin
      pos <= pos + 1'b1;
      if (kind == prnf_pkg::CK_DIGIT) begin
        cur.digits <= {cur.digits[prnf_pkg::DIGIT_BITS-5:0], 4'b0000};
      end
    end
    if (step) begin
      o_char <= ch;
      o_last <= is_last;
    end
  end

endmodule

// ===== src/padded_radix_number_formatter.sv =====
// Top level of the padded radix number formatter: front end, job queue, back end.
// Flow: a number's first character leaves once the front end has built its digits, the
//   job has passed the queue and the back end has loaded it; for decimal the front end
//   first runs the shift-and-add-three BCD loop. The back end sends one character per
//   cycle while the receiver is ready and loads each job between numbers, so the slower
//   of the two sets the rate.
// Reset: synchronous; clears both state machines, the queue and the output valid flag.
module padded_radix_number_formatter #(
  parameter int MAX_WIDTH  = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  prnf_in_if.sink     number,
  prnf_out_if.source  chars
);

  // Front to queue
  prnf_pkg::job_t      f_job;
  logic                f_valid;
  logic                f_ready;

  // Queue to back
  prnf_pkg::job_t      q_job;
  logic                q_valid;
  logic                q_ready;
  prnf_pkg::q_status_t q_stat;

  // Accept a word, build its digit string and field layout
  prnf_front #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .number    (number),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  // Hold finished jobs so the front can start the next number while characters drain
  prnf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_job    (f_job),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_job   (q_job),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .status    (q_stat)
  );

  // Walk each job's field and send its characters, leftmost first
  prnf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_job),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .chars     (chars)
  );

  // The front end works on one number at a time: it drops ready after taking a word
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (number.valid && number.ready) |=> !number.ready)
    else $error("front end took a word while busy");

  // Queue count stays consistent
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  // A pushed job is held at least until the next cycle
  a_queue_push: assert property (@(posedge clk) disable iff (rst)
    (f_valid && f_ready) |=> !q_stat.empty)
    else $error("pushed job lost from queue");

endmodule
